>>> rtl/core/scq_pkg.sv
// Shared types, scan code constants and character lookup functions for the
// scan code to ASCII queue. Depends on nothing; used by scq_keys, scq_queue and the top level.
package scq_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int BYTE_W          = 8;
    localparam int CHAR_W          = 7;
    localparam int DROP_W          = 32;
    localparam int FILL_W          = 7;
    localparam int CODE_W          = 7;

    localparam logic [BYTE_W-1:0] CODE_PREFIX  = 8'hE0;
    localparam logic [CODE_W-1:0] CODE_LSHIFT  = 7'h2A;
    localparam logic [CODE_W-1:0] CODE_RSHIFT  = 7'h36;
    localparam logic [CODE_W-1:0] CODE_CAPS    = 7'h3A;
    localparam logic [CODE_W-1:0] CODE_ENTER   = 7'h1C;
    localparam logic [CODE_W-1:0] CODE_BKSP    = 7'h0E;
    localparam logic [CODE_W-1:0] CODE_SPACE   = 7'h39;
    localparam logic [CODE_W-1:0] CODE_DIGIT_LO = 7'h02;
    localparam logic [CODE_W-1:0] CODE_DIGIT_HI = 7'h0B;

    localparam logic [CHAR_W-1:0] CHAR_NONE    = 7'h00;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 7'h0A;
    localparam logic [CHAR_W-1:0] CHAR_BKSP    = 7'h08;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 7'h20;
    localparam logic [CHAR_W-1:0] CASE_OFFSET  = 7'h20;

    typedef enum logic {
        FUNC_FEED = 1'b0,
        FUNC_POP  = 1'b1
    } func_t;

    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] ch;
    } push_req_t;

    function automatic logic [CHAR_W-1:0] letter_lookup(input logic [CODE_W-1:0] code);
        logic [CHAR_W-1:0] c;
        case (code)
            7'h1E: c = 7'h61; 7'h30: c = 7'h62; 7'h2E: c = 7'h63; 7'h20: c = 7'h64;
            7'h12: c = 7'h65; 7'h21: c = 7'h66; 7'h22: c = 7'h67; 7'h23: c = 7'h68;
            7'h17: c = 7'h69; 7'h24: c = 7'h6A; 7'h25: c = 7'h6B; 7'h26: c = 7'h6C;
            7'h32: c = 7'h6D; 7'h31: c = 7'h6E; 7'h18: c = 7'h6F; 7'h19: c = 7'h70;
            7'h10: c = 7'h71; 7'h13: c = 7'h72; 7'h1F: c = 7'h73; 7'h14: c = 7'h74;
            7'h16: c = 7'h75; 7'h2F: c = 7'h76; 7'h11: c = 7'h77; 7'h2D: c = 7'h78;
            7'h15: c = 7'h79; 7'h2C: c = 7'h7A;
            default: c = CHAR_NONE;
        endcase
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_lookup(input logic [3:0] k,
                                                       input logic shifted);
        logic [CHAR_W-1:0] plain;
        logic [CHAR_W-1:0] shf;
        case (k)
            4'd0: begin plain = 7'h31; shf = 7'h21; end
            4'd1: begin plain = 7'h32; shf = 7'h40; end
            4'd2: begin plain = 7'h33; shf = 7'h23; end
            4'd3: begin plain = 7'h34; shf = 7'h24; end
            4'd4: begin plain = 7'h35; shf = 7'h25; end
            4'd5: begin plain = 7'h36; shf = 7'h5E; end
            4'd6: begin plain = 7'h37; shf = 7'h26; end
            4'd7: begin plain = 7'h38; shf = 7'h2A; end
            4'd8: begin plain = 7'h39; shf = 7'h28; end
            4'd9: begin plain = 7'h30; shf = 7'h29; end
            default: begin plain = CHAR_NONE; shf = CHAR_NONE; end
        endcase
        return shifted ? shf : plain;
    endfunction

endpackage

>>> rtl/core/scq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module scq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/scq_keys.sv
// Keyboard state tracking and scan code to ASCII translation.
// Depends on scq_pkg.
module scq_keys (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          feed_fire,
    input  logic [scq_pkg::BYTE_W-1:0]    scan_byte,
    output scq_pkg::push_req_t            push_req
);

    logic lshift_reg, lshift_next;
    logic rshift_reg, rshift_next;
    logic caps_reg, caps_next;
    logic prefix_reg, prefix_next;

    logic                          is_prefix;
    logic                          released;
    logic [scq_pkg::CODE_W-1:0]    code;
    logic                          shifted;
    logic [scq_pkg::CHAR_W-1:0]    letter;
    logic                          is_digit;
    logic [scq_pkg::CODE_W-1:0]    digit_k;
    logic                          mapped;
    logic [scq_pkg::CHAR_W-1:0]    ch;

    assign is_prefix = (scan_byte == scq_pkg::CODE_PREFIX);
    assign released  = scan_byte[scq_pkg::BYTE_W-1];
    assign code      = scan_byte[scq_pkg::CODE_W-1:0];
    assign shifted   = lshift_reg | rshift_reg;
    assign letter    = scq_pkg::letter_lookup(code);
    assign is_digit  = (code >= scq_pkg::CODE_DIGIT_LO) && (code <= scq_pkg::CODE_DIGIT_HI);
    assign digit_k   = code - scq_pkg::CODE_DIGIT_LO;

    always_comb begin
        mapped = 1'b1;
        ch     = scq_pkg::CHAR_NONE;
        if (letter != scq_pkg::CHAR_NONE) begin
            ch = (shifted != caps_reg) ? (letter - scq_pkg::CASE_OFFSET) : letter;
        end else if (is_digit) begin
            ch = scq_pkg::digit_lookup(digit_k[3:0], shifted);
        end else if (code == scq_pkg::CODE_ENTER) begin
            ch = scq_pkg::CHAR_NEWLINE;
        end else if (code == scq_pkg::CODE_BKSP) begin
            ch = scq_pkg::CHAR_BKSP;
        end else if (code == scq_pkg::CODE_SPACE) begin
            ch = scq_pkg::CHAR_SPACE;
        end else begin
            mapped = 1'b0;
        end
    end

    assign push_req.valid = feed_fire && !is_prefix && !prefix_reg && !released && mapped;
    assign push_req.ch    = ch;

    always_comb begin
        lshift_next = lshift_reg;
        rshift_next = rshift_reg;
        caps_next   = caps_reg;
        prefix_next = prefix_reg;
        if (feed_fire) begin
            if (is_prefix) begin
                prefix_next = 1'b1;
            end else if (prefix_reg) begin
                prefix_next = 1'b0;
            end else if (code == scq_pkg::CODE_LSHIFT) begin
                lshift_next = !released;
            end else if (code == scq_pkg::CODE_RSHIFT) begin
                rshift_next = !released;
            end else if (code == scq_pkg::CODE_CAPS && !released) begin
                caps_next = !caps_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lshift_reg <= 1'b0;
            rshift_reg <= 1'b0;
            caps_reg   <= 1'b0;
            prefix_reg <= 1'b0;
        end else begin
            lshift_reg <= lshift_next;
            rshift_reg <= rshift_next;
            caps_reg   <= caps_next;
            prefix_reg <= prefix_next;
        end
    end

endmodule

>>> rtl/core/scq_queue.sv
// Character FIFO with wrapping write and read counts and a drop counter.
// Depends on scq_pkg and scq_ram.
module scq_queue #(
    parameter int QUEUE_DEPTH = scq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  scq_pkg::push_req_t            push_req,
    input  logic                          pop_fire,
    output logic                          accepted,
    output logic [scq_pkg::CHAR_W-1:0]    rd_char,
    output logic [scq_pkg::DROP_W-1:0]    dropped_count,
    output logic [scq_pkg::FILL_W-1:0]    fill_level
);

    localparam int CW = $clog2(2 * QUEUE_DEPTH);
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] LAST_C  = CW'(2 * QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] SPAN_C  = CW'(2 * QUEUE_DEPTH);

    logic [CW-1:0]              wcnt_reg, wcnt_next;
    logic [CW-1:0]              rcnt_reg, rcnt_next;
    logic [scq_pkg::DROP_W-1:0] drop_reg, drop_next;

    logic [CW-1:0] fill;
    logic [CW-1:0] waddr_full;
    logic [CW-1:0] raddr_full;
    logic          full;
    logic          empty;
    logic          do_write;
    logic          do_read;

    assign fill       = (wcnt_reg >= rcnt_reg) ? (wcnt_reg - rcnt_reg)
                                               : (wcnt_reg - rcnt_reg + SPAN_C);
    assign full       = (fill == DEPTH_C);
    assign empty      = (fill == '0);
    assign waddr_full = (wcnt_reg >= DEPTH_C) ? (wcnt_reg - DEPTH_C) : wcnt_reg;
    assign raddr_full = (rcnt_reg >= DEPTH_C) ? (rcnt_reg - DEPTH_C) : rcnt_reg;
    assign do_write   = push_req.valid && !full;
    assign do_read    = pop_fire && !empty;
    assign accepted   = do_write || do_read;

    always_comb begin
        wcnt_next = wcnt_reg;
        rcnt_next = rcnt_reg;
        drop_next = drop_reg;
        if (do_write) begin
            wcnt_next = (wcnt_reg == LAST_C) ? '0 : wcnt_reg + CW'(1);
        end
        if (push_req.valid && full) begin
            drop_next = drop_reg + scq_pkg::DROP_W'(1);
        end
        if (do_read) begin
            rcnt_next = (rcnt_reg == LAST_C) ? '0 : rcnt_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wcnt_reg <= '0;
            rcnt_reg <= '0;
            drop_reg <= '0;
        end else begin
            wcnt_reg <= wcnt_next;
            rcnt_reg <= rcnt_next;
            drop_reg <= drop_next;
        end
    end

    scq_ram #(
        .WIDTH (scq_pkg::CHAR_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (aclk),
        .we    (do_write),
        .waddr (waddr_full[AW-1:0]),
        .wdata (push_req.ch),
        .re    (do_read),
        .raddr (raddr_full[AW-1:0]),
        .rdata (rd_char)
    );

    assign dropped_count = drop_reg;
    assign fill_level    = scq_pkg::FILL_W'(fill);

endmodule

>>> rtl/core/scancode_to_ascii_queue.sv
// Scan code set 1 keyboard decoder feeding a character FIFO, top level.
// Each beat passes a staging register, which covers the queue RAM's registered read,
// then the output register. Throughput: one beat per cycle unless m_tready stalls.
// Reset (aresetn low, synchronous) empties the queue, zeroes the drop counter
// and clears shift, caps lock and prefix state; queue RAM contents are not cleared.
module scancode_to_ascii_queue #(
    parameter int QUEUE_DEPTH = scq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] scan_byte
    input  logic        s_tuser,   // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [6:0] character, [38:7] dropped_count,
                                   // [45:39] fill_level, [47:46] zero
    output logic        m_tuser    // [0] accepted
);

    logic                          s_fire;
    logic                          feed_fire;
    logic                          pop_fire;
    scq_pkg::push_req_t            push_req;
    logic                          q_accepted;
    logic [scq_pkg::CHAR_W-1:0]    rd_char;
    logic [scq_pkg::DROP_W-1:0]    dropped_count;
    logic [scq_pkg::FILL_W-1:0]    fill_level;

    logic                          st_valid_reg, st_valid_next;
    logic                          st_acc_reg;
    logic                          st_pop_reg;
    logic                          out_valid_reg, out_valid_next;
    logic                          out_acc_reg;
    logic [scq_pkg::CHAR_W-1:0]    out_char_reg;
    logic [scq_pkg::DROP_W-1:0]    out_drop_reg;
    logic [scq_pkg::FILL_W-1:0]    out_fill_reg;
    logic                          out_ready;
    logic                          st_move;

    assign out_ready = !out_valid_reg || m_tready;
    assign st_move   = st_valid_reg && out_ready;
    assign s_tready  = !st_valid_reg || out_ready;
    assign s_fire    = s_tvalid && s_tready;
    assign feed_fire = s_fire && (scq_pkg::func_t'(s_tuser) == scq_pkg::FUNC_FEED);
    assign pop_fire  = s_fire && (scq_pkg::func_t'(s_tuser) == scq_pkg::FUNC_POP);

    scq_keys u_keys (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .feed_fire (feed_fire),
        .scan_byte (s_tdata),
        .push_req  (push_req)
    );

    scq_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .push_req      (push_req),
        .pop_fire      (pop_fire),
        .accepted      (q_accepted),
        .rd_char       (rd_char),
        .dropped_count (dropped_count),
        .fill_level    (fill_level)
    );

    always_comb begin
        st_valid_next = st_valid_reg;
        if (s_fire) begin
            st_valid_next = 1'b1;
        end else if (st_move) begin
            st_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (st_move) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            st_valid_reg  <= st_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            st_acc_reg <= q_accepted;
            st_pop_reg <= pop_fire;
        end
        if (st_move) begin
            out_acc_reg  <= st_acc_reg;
            out_char_reg <= (st_pop_reg && st_acc_reg) ? rd_char : scq_pkg::CHAR_NONE;
            out_drop_reg <= dropped_count;
            out_fill_reg <= fill_level;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_acc_reg;
    assign m_tdata  = {2'b00, out_fill_reg, out_drop_reg, out_char_reg};

endmodule

>>> rtl/core/scq_checker.sv
// Port-level checks for the scan code to ASCII queue, bound to the top level.
// Depends on scancode_to_ascii_queue.
module scq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser
);

    logic m_beat;

    assign m_beat = m_tvalid && m_tready;

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Result beat offered right after reset.");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Stalled result beat changed.");

    a_no_char_when_refused: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[6:0] == 7'h00)
        else $error("Character present on a beat that was not accepted.");

    a_drop_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_beat ##1 m_beat |->
            (m_tdata[38:7] == $past(m_tdata[38:7])) ||
            (m_tdata[38:7] == $past(m_tdata[38:7]) + 32'd1))
        else $error("Drop count moved by more than one between consecutive results.");

endmodule

bind scancode_to_ascii_queue scq_checker u_scq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
